/* rtl/ktbl_pkg.sv */
package ktbl_pkg;

    localparam int CMD_ENTRIES = 64;
    localparam int RESYNC_ENTRIES = 16;
    localparam int CMD_IDX_W = $clog2(CMD_ENTRIES);
    localparam int RSY_IDX_W = $clog2(RESYNC_ENTRIES);
    localparam int RESYNC_WINDOW_FACTOR = 60;

    localparam logic [1:0] REG_TICK_RATE = 2'd0;
    localparam logic [1:0] REG_DEFAULT_RATE = 2'd1;
    localparam logic [1:0] REG_CMD_CAP = 2'd2;
    localparam logic [1:0] REG_RSY_CAP = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_LIMITED = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [15:0] credit;
        logic [31:0] stamp;
    } bucket_t;

endpackage

/* rtl/keyed_token_bucket_limiter_unit.sv */
// Keyed token bucket limiter.
// Requests enter on the s_ channel: tdata holds op, peer, component and now.
// Each request yields one transaction on the m_ channel whose tdata holds
// status and detail. Command buckets are keyed by peer and component, resync
// buckets by peer; a miss takes the lowest free slot or the least recently
// used entry. Configuration registers are written through cfg_we, cfg_addr
// and cfg_wdata; the user must write them only while the block is idle, as
// the block itself does not enforce it. The key match and recency update
// happen at the accepting edge. A request then passes through one bucket
// memory read, a cost division by the capacity that produces one quotient
// bit a cycle, a credit update and write-back, and the load of the output
// register. The next request is accepted only once the block is idle again,
// so it takes no new request before the last is through. A request with a
// zero capacity or window skips the division.
// After reset all entries are free and registers hold their reset values.
// When the receiver stalls, one finished result waits in the output register
// while the next request is taken and processed; that request then waits
// until the output register empties, and input is held off until it has.
module keyed_token_bucket_limiter_unit
    import ktbl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op[0], peer[16:1], component[32:17], now[64:33]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[1:0], detail[17:2]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_DIV, S_UPD, S_OUT} state_t;

    state_t state_reg;
    logic [9:0] tick_rate_reg, default_rate_reg;
    logic [7:0] cmd_cap_reg, rsy_cap_reg;

    logic                  op_reg;
    logic [15:0]           peer_reg, comp_reg;
    logic [31:0]           now_reg;
    logic [CMD_IDX_W-1:0]  cidx_reg;
    logic [RSY_IDX_W-1:0]  ridx_reg;

    logic [CMD_ENTRIES-1:0]    cvalid_reg, cstart_reg;
    logic [15:0]               cpeer_reg [CMD_ENTRIES];
    logic [15:0]               ccomp_reg [CMD_ENTRIES];
    logic [CMD_IDX_W-1:0]      crec_reg  [CMD_ENTRIES];
    logic [RESYNC_ENTRIES-1:0] rvalid_reg, rstart_reg;
    logic [15:0]               rpeer_reg [RESYNC_ENTRIES];
    logic [RSY_IDX_W-1:0]      rrec_reg  [RESYNC_ENTRIES];

    bucket_t cmem [CMD_ENTRIES];
    bucket_t rmem [RESYNC_ENTRIES];
    bucket_t rd_reg;
    logic    started_reg;

    logic [15:0] window_reg;
    logic [7:0]  cap_reg;
    logic [15:0] quot_reg;
    logic [8:0]  rem_reg;
    logic [3:0]  cnt_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg, res_status_reg;
    logic [15:0] out_detail_reg, res_detail_reg;

    // Key match and victim choice.
    logic                 chit, rhit, cfree, rfree;
    logic [CMD_IDX_W-1:0] chit_i, cfree_i, cold_i, csel;
    logic [RSY_IDX_W-1:0] rhit_i, rfree_i, rold_i, rsel;
    logic [15:0] in_peer, in_comp;
    logic        in_op;

    assign in_op = s_tdata[0];
    assign in_peer = s_tdata[16:1];
    assign in_comp = s_tdata[32:17];

    always_comb begin
        chit = 1'b0; chit_i = '0; cfree = 1'b0; cfree_i = '0; cold_i = '0;
        for (int i = CMD_ENTRIES - 1; i >= 0; i--) begin
            if (cvalid_reg[i] && cpeer_reg[i] == in_peer && ccomp_reg[i] == in_comp) begin
                chit = 1'b1; chit_i = CMD_IDX_W'(i);
            end
            if (!cvalid_reg[i]) begin
                cfree = 1'b1; cfree_i = CMD_IDX_W'(i);
            end
            if (crec_reg[i] == CMD_IDX_W'(CMD_ENTRIES - 1)) cold_i = CMD_IDX_W'(i);
        end
        csel = chit ? chit_i : (cfree ? cfree_i : cold_i);
        rhit = 1'b0; rhit_i = '0; rfree = 1'b0; rfree_i = '0; rold_i = '0;
        for (int i = RESYNC_ENTRIES - 1; i >= 0; i--) begin
            if (rvalid_reg[i] && rpeer_reg[i] == in_peer) begin
                rhit = 1'b1; rhit_i = RSY_IDX_W'(i);
            end
            if (!rvalid_reg[i]) begin
                rfree = 1'b1; rfree_i = RSY_IDX_W'(i);
            end
            if (rrec_reg[i] == RSY_IDX_W'(RESYNC_ENTRIES - 1)) rold_i = RSY_IDX_W'(i);
        end
        rsel = rhit ? rhit_i : (rfree ? rfree_i : rold_i);
    end

    logic [9:0]  rate;
    logic [15:0] window_next;
    logic        accept;
    logic        res_pending;

    assign rate = (tick_rate_reg == 10'd0) ? default_rate_reg : tick_rate_reg;
    assign window_next = in_op ? 16'(rate * 16'(RESYNC_WINDOW_FACTOR)) : {6'd0, rate};
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign res_pending = (state_reg == S_OUT);

    // Credit update.
    logic [32:0] sum;
    logic [15:0] credit_upd;
    logic        advance;
    logic [16:0] cost;

    assign advance = now_reg > rd_reg.stamp;
    assign sum = {17'd0, rd_reg.credit} + {1'b0, now_reg - rd_reg.stamp};
    assign cost = {1'b0, quot_reg} + {16'd0, rem_reg != 9'd0};
    always_comb begin
        if (!started_reg) credit_upd = window_reg;
        else if (advance) credit_upd = (sum < {17'd0, window_reg}) ? sum[15:0] : window_reg;
        else credit_upd = rd_reg.credit;
    end

    logic [8:0] rem_shift;
    assign rem_shift = {rem_reg[7:0], window_reg[4'd15 - cnt_reg]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            cvalid_reg <= '0;
            cstart_reg <= '0;
            rvalid_reg <= '0;
            rstart_reg <= '0;
            for (int i = 0; i < CMD_ENTRIES; i++) crec_reg[i] <= '0;
            for (int i = 0; i < RESYNC_ENTRIES; i++) rrec_reg[i] <= '0;
            tick_rate_reg <= '0;
            default_rate_reg <= 10'd60;
            cmd_cap_reg <= 8'd30;
            rsy_cap_reg <= 8'd4;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TICK_RATE:    tick_rate_reg <= cfg_wdata;
                    REG_DEFAULT_RATE: default_rate_reg <= cfg_wdata;
                    REG_CMD_CAP:      cmd_cap_reg <= cfg_wdata[7:0];
                    REG_RSY_CAP:      rsy_cap_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg <= in_op;
                        peer_reg <= in_peer;
                        comp_reg <= in_comp;
                        now_reg <= s_tdata[64:33];
                        window_reg <= window_next;
                        cap_reg <= in_op ? rsy_cap_reg : cmd_cap_reg;
                        cidx_reg <= csel;
                        ridx_reg <= rsel;
                        if (!in_op) begin
                            for (int i = 0; i < CMD_ENTRIES; i++) begin
                                if (CMD_IDX_W'(i) != csel && cvalid_reg[i] &&
                                    (!chit || crec_reg[i] < crec_reg[csel]))
                                    crec_reg[i] <= crec_reg[i] + 1'b1;
                            end
                            crec_reg[csel] <= '0;
                            cvalid_reg[csel] <= 1'b1;
                            cpeer_reg[csel] <= in_peer;
                            ccomp_reg[csel] <= in_comp;
                            started_reg <= chit && cstart_reg[csel];
                        end else begin
                            for (int i = 0; i < RESYNC_ENTRIES; i++) begin
                                if (RSY_IDX_W'(i) != rsel && rvalid_reg[i] &&
                                    (!rhit || rrec_reg[i] < rrec_reg[rsel]))
                                    rrec_reg[i] <= rrec_reg[i] + 1'b1;
                            end
                            rrec_reg[rsel] <= '0;
                            rvalid_reg[rsel] <= 1'b1;
                            rpeer_reg[rsel] <= in_peer;
                            started_reg <= rhit && rstart_reg[rsel];
                        end
                        if (!in_op && !chit) cstart_reg[csel] <= 1'b0;
                        if (in_op && !rhit) rstart_reg[rsel] <= 1'b0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    rd_reg <= op_reg ? rmem[ridx_reg] : cmem[cidx_reg];
                    quot_reg <= '0;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= (window_reg == 16'd0 || cap_reg == 8'd0) ? S_UPD : S_DIV;
                end
                S_DIV: begin
                    if (rem_shift >= {1'b0, cap_reg}) begin
                        rem_reg <= rem_shift - {1'b0, cap_reg};
                        quot_reg <= {quot_reg[14:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift;
                        quot_reg <= {quot_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15) state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (window_reg == 16'd0 || cap_reg == 8'd0) begin
                        res_status_reg <= ST_INVALID;
                        res_detail_reg <= window_reg;
                    end else begin
                        if (op_reg) begin
                            rstart_reg[ridx_reg] <= 1'b1;
                            rmem[ridx_reg].stamp <= (!started_reg || advance) ? now_reg
                                                    : rd_reg.stamp;
                        end else begin
                            cstart_reg[cidx_reg] <= 1'b1;
                            cmem[cidx_reg].stamp <= (!started_reg || advance) ? now_reg
                                                    : rd_reg.stamp;
                        end
                        if ({1'b0, credit_upd} < cost) begin
                            res_status_reg <= ST_LIMITED;
                            res_detail_reg <= credit_upd;
                            if (op_reg) rmem[ridx_reg].credit <= credit_upd;
                            else cmem[cidx_reg].credit <= credit_upd;
                        end else begin
                            res_status_reg <= ST_OK;
                            res_detail_reg <= '0;
                            if (op_reg) rmem[ridx_reg].credit <= credit_upd - cost[15:0];
                            else cmem[cidx_reg].credit <= credit_upd - cost[15:0];
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!out_valid_reg || m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (res_pending && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
                out_status_reg <= res_status_reg;
                out_detail_reg <= res_detail_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_detail_reg, out_status_reg};

endmodule

/* verif/testbench.sv */
module testbench
    import ktbl_pkg::*;
();

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;

    keyed_token_bucket_limiter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] detail;
    } verdict_t;

    localparam int WATCHDOG_LIMIT = 20000;

    // Predictor copy of the configuration and both bucket tables.
    logic [9:0]  p_tick_rate;
    logic [9:0]  p_default_rate;
    logic [7:0]  p_cmd_cap;
    logic [7:0]  p_rsy_cap;

    bit          c_valid [CMD_ENTRIES];
    bit          c_started [CMD_ENTRIES];
    logic [15:0] c_peer [CMD_ENTRIES];
    logic [15:0] c_comp [CMD_ENTRIES];
    logic [15:0] c_credit [CMD_ENTRIES];
    logic [31:0] c_last [CMD_ENTRIES];
    int          c_rank [CMD_ENTRIES];

    bit          r_valid [RESYNC_ENTRIES];
    bit          r_started [RESYNC_ENTRIES];
    logic [15:0] r_peer [RESYNC_ENTRIES];
    logic [15:0] r_credit [RESYNC_ENTRIES];
    logic [31:0] r_last [RESYNC_ENTRIES];
    int          r_rank [RESYNC_ENTRIES];

    verdict_t    pending_verdicts[$];
    int          errors = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          limited_seen = 0;
    int          invalid_seen = 0;
    bit          rand_stall = 1'b1;

    function automatic verdict_t charge_bucket(inout bit started, inout logic [15:0] credit,
                                               inout logic [31:0] last, input logic [31:0] now,
                                               input int unsigned window,
                                               input int unsigned cap);
        verdict_t v;
        longint unsigned sum;
        int unsigned cost;
        if (window == 0 || cap == 0) begin
            v.status = ST_INVALID;
            v.detail = window[15:0];
            return v;
        end
        if (!started) begin
            credit = window[15:0];
            last = now;
            started = 1'b1;
        end else if (now > last) begin
            sum = longint'(credit) + longint'(now - last);
            credit = (sum < window) ? sum[15:0] : window[15:0];
            last = now;
        end
        cost = (window + cap - 1) / cap;
        if (credit < cost) begin
            v.status = ST_LIMITED;
            v.detail = credit;
            return v;
        end
        credit = credit - cost[15:0];
        v.status = ST_OK;
        v.detail = '0;
        return v;
    endfunction

    function automatic verdict_t admit_request(bit op, logic [15:0] peer,
                                               logic [15:0] comp, logic [31:0] now);
        int unsigned rate;
        int idx;
        int lim;
        bit hit;
        bit was;
        rate = 32'((p_tick_rate == 0) ? p_default_rate : p_tick_rate);
        idx = -1;
        if (!op) begin
            for (int i = 0; i < CMD_ENTRIES; i++)
                if (idx < 0 && c_valid[i] && c_peer[i] == peer && c_comp[i] == comp) idx = i;
            hit = idx >= 0;
            if (!hit) begin
                for (int i = CMD_ENTRIES - 1; i >= 0; i--) if (!c_valid[i]) idx = i;
                if (idx < 0) begin
                    idx = 0;
                    for (int i = 1; i < CMD_ENTRIES; i++) if (c_rank[i] > c_rank[idx]) idx = i;
                end
                c_peer[idx] = peer;
                c_comp[idx] = comp;
                c_started[idx] = 1'b0;
            end
            was = c_valid[idx];
            lim = was ? c_rank[idx] : CMD_ENTRIES;
            for (int i = 0; i < CMD_ENTRIES; i++)
                if (i != idx && c_valid[i] && c_rank[i] < lim) c_rank[i]++;
            c_rank[idx] = 0;
            c_valid[idx] = 1'b1;
            return charge_bucket(c_started[idx], c_credit[idx], c_last[idx], now, rate,
                                 32'(p_cmd_cap));
        end
        for (int i = 0; i < RESYNC_ENTRIES; i++)
            if (idx < 0 && r_valid[i] && r_peer[i] == peer) idx = i;
        hit = idx >= 0;
        if (!hit) begin
            for (int i = RESYNC_ENTRIES - 1; i >= 0; i--) if (!r_valid[i]) idx = i;
            if (idx < 0) begin
                idx = 0;
                for (int i = 1; i < RESYNC_ENTRIES; i++) if (r_rank[i] > r_rank[idx]) idx = i;
            end
            r_peer[idx] = peer;
            r_started[idx] = 1'b0;
        end
        was = r_valid[idx];
        lim = was ? r_rank[idx] : RESYNC_ENTRIES;
        for (int i = 0; i < RESYNC_ENTRIES; i++)
            if (i != idx && r_valid[i] && r_rank[i] < lim) r_rank[i]++;
        r_rank[idx] = 0;
        r_valid[idx] = 1'b1;
        return charge_bucket(r_started[idx], r_credit[idx], r_last[idx], now,
                             rate * RESYNC_WINDOW_FACTOR, 32'(p_rsy_cap));
    endfunction

    // The request stays valid past its accepting edge until the next call or a drain
    // decides whether a new request follows at once.
    task automatic send_request(bit op, logic [15:0] peer, logic [15:0] comp,
                                logic [31:0] now);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {7'd0, now, comp, peer, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_verdicts.push_back(admit_request(op, peer, comp, now));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] index, logic [9:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            REG_TICK_RATE:    p_tick_rate = value;
            REG_DEFAULT_RATE: p_default_rate = value;
            REG_CMD_CAP:      p_cmd_cap = value[7:0];
            REG_RSY_CAP:      p_rsy_cap = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_rates(logic [9:0] tick, logic [9:0] dflt, logic [7:0] ccap,
                             logic [7:0] rcap);
        wait_drained();
        write_register(REG_TICK_RATE, tick);
        write_register(REG_DEFAULT_RATE, dflt);
        write_register(REG_CMD_CAP, {2'b00, ccap});
        write_register(REG_RSY_CAP, {2'b00, rcap});
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("keyed_token_bucket_limiter_unit verification failed");
                $finish;
            end
            if (rand_stall) m_tready <= ($urandom_range(0, 8) < 5);
            else m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction %h", $time, m_tdata);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[1:0] != want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_tdata[1:0]);
                end
                if (m_tdata[17:2] != want.detail) begin
                    errors++;
                    $display("%0t: detail expected %0d actual %0d", $time, want.detail,
                             m_tdata[17:2]);
                end
                if (want.status == ST_LIMITED) limited_seen++;
                if (want.status == ST_INVALID) invalid_seen++;
            end
        end
    end

    task automatic test_directed();
        logic [31:0] t;
        t = 32'd100;
        send_request(1'b0, 16'h0000, 16'h0000, t);
        send_request(1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(1'b1, 16'hFFFF, 16'h1234, 32'd0);
        for (int i = 0; i < 6; i++) send_request(1'b1, 16'h0005, 16'h0000, t);
        for (int i = 0; i < 5; i++) send_request(1'b0, 16'h0007, 16'h0009, t - i);
        send_request(1'b0, 16'h0007, 16'h0009, t + 32'd500);
        send_request(1'b0, 16'h0000, 16'h0000, t);
        set_rates(10'd0, 10'd1000, 8'd255, 8'd255);
        send_request(1'b1, 16'h0042, 16'h0, 32'h8000_0000);
        send_request(1'b0, 16'hAAAA, 16'h5555, 32'h8000_0000);
        set_rates(10'd1, 10'd1, 8'd1, 8'd1);
        send_request(1'b0, 16'hAAAA, 16'h5555, 32'h8000_0001);
        send_request(1'b0, 16'hAAAA, 16'h5555, 32'h8000_0001);
        set_rates(10'd0, 10'd0, 8'd0, 8'd0);
        send_request(1'b0, 16'h0001, 16'h0002, 32'd5);
        send_request(1'b1, 16'h0001, 16'h0002, 32'd5);
        set_rates(10'd1000, 10'd60, 8'd0, 8'd0);
        send_request(1'b0, 16'h0003, 16'h0002, 32'd5);
        send_request(1'b1, 16'h0003, 16'h0002, 32'd5);
    endtask

    task automatic test_random(int count);
        logic [31:0] clock_base;
        bit op;
        logic [15:0] peer;
        logic [15:0] comp;
        logic [31:0] now;
        clock_base = $urandom();
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8) begin
                peer = 16'($urandom_range(0, 23));
                comp = 16'($urandom_range(0, 79));
            end else begin
                peer = 16'($urandom());
                comp = 16'($urandom());
            end
            case ($urandom_range(0, 9))
                0: now = $urandom();
                1: now = clock_base - $urandom_range(0, 50);
                default: begin
                    clock_base = clock_base + $urandom_range(0, 40);
                    now = clock_base;
                end
            endcase
            send_request(op, peer, comp, now);
        end
    endtask

    task automatic test_stall_free(int count);
        rand_stall = 1'b0;
        test_random(count);
        wait_drained();
        rand_stall = 1'b1;
    endtask

    initial begin
        p_tick_rate = '0;
        p_default_rate = 10'd60;
        p_cmd_cap = 8'd30;
        p_rsy_cap = 8'd4;
        for (int i = 0; i < CMD_ENTRIES; i++) begin
            c_valid[i] = 0; c_started[i] = 0; c_rank[i] = 0;
        end
        for (int i = 0; i < RESYNC_ENTRIES; i++) begin
            r_valid[i] = 0; r_started[i] = 0; r_rank[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        set_rates(10'd0, 10'd60, 8'd30, 8'd4);
        test_random(400);
        set_rates(10'd20, 10'd1, 8'd7, 8'd3);
        test_random(400);
        set_rates(10'd1023, 10'd1023, 8'd255, 8'd255);
        test_stall_free(150);
        set_rates(10'd0, 10'd13, 8'd2, 8'd1);
        test_random(350);
        set_rates(10'd5, 10'd60, 8'd1, 8'd0);
        test_random(250);
        wait_drained();
        $display("Sent %0d requests and checked %0d transactions.", items_sent, results_seen);
        $display("Rate limited %0d, invalid %0d, across several configuration phases.",
                 limited_seen, invalid_seen);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("keyed_token_bucket_limiter_unit verification clean");
        end else begin
            $display("keyed_token_bucket_limiter_unit verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ktbl_pkg.sv
rtl/keyed_token_bucket_limiter_unit.sv
verif/testbench.sv
